// ----- src/lcr_pkg.sv -----
package lcr_pkg;

    // Field widths fixed by the stream formats.
    localparam int COORD_W = 6;
    localparam int INDEX_W = 12;
    localparam int ROW_W   = 7;
    localparam int ERR_W   = 8;
    localparam int IN_W    = 4 * COORD_W;
    localparam int OUT_W   = 2 * COORD_W + INDEX_W;

    // Row width after reset.
    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 7'd64;

    // Controller phases.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT_END,
        ST_WALK
    } lcr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit_end;
        logic emit_walk;
    } lcr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic same_point;
        logic walk_last;
    } lcr_status_t;

endpackage

// ----- src/lcr_ctrl.sv -----
module lcr_ctrl
    import lcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  lcr_status_t status,
    output lcr_cmd_t    cmd
);

    lcr_state_t state_reg;
    lcr_state_t state_next;
    logic       valid_reg;
    logic       valid_next;
    logic       slot_free;

    // The output register can take a cell when empty or when its cell is being transferred.
    assign slot_free = !valid_reg || out_ready;

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.emit_end  = 1'b0;
        cmd.emit_walk = 1'b0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT_END;
                end
            end
            ST_EMIT_END:
            begin
                if (slot_free)
                begin
                    cmd.emit_end = 1'b1;
                    state_next   = status.same_point ? ST_IDLE : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (slot_free)
                begin
                    cmd.emit_walk = 1'b1;
                    if (status.walk_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit_end || cmd.emit_walk)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    assign out_valid = valid_reg;

endmodule

// ----- src/lcr_datapath.sv -----
module lcr_datapath
    import lcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [ROW_W-1:0] cfg_data,
    input  logic [IN_W-1:0]  in_data,
    input  lcr_cmd_t         cmd,
    output lcr_status_t      status,
    output logic [OUT_W-1:0] out_data,
    output logic             out_last
);

    logic [ROW_W-1:0]          row_width_reg;
    logic [COORD_W-1:0]        walk_x_reg;
    logic [COORD_W-1:0]        walk_y_reg;
    logic [COORD_W-1:0]        goal_x_reg;
    logic [COORD_W-1:0]        goal_y_reg;
    logic [COORD_W-1:0]        span_x_reg;
    logic [COORD_W-1:0]        span_y_reg;
    logic                      dir_x_neg_reg;
    logic                      dir_y_neg_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic [COORD_W-1:0]        cell_x_reg;
    logic [COORD_W-1:0]        cell_y_reg;
    logic [INDEX_W-1:0]        cell_index_reg;
    logic                      last_reg;

    logic [COORD_W-1:0]        in_sx;
    logic [COORD_W-1:0]        in_sy;
    logic [COORD_W-1:0]        in_ex;
    logic [COORD_W-1:0]        in_ey;
    logic [COORD_W-1:0]        load_dx;
    logic [COORD_W-1:0]        load_dy;
    logic signed [ERR_W-1:0]   load_err;

    logic signed [ERR_W:0]     e2;
    logic signed [ERR_W:0]     dx_s;
    logic signed [ERR_W:0]     neg_dy;
    logic                      step_x;
    logic                      step_y;
    logic signed [ERR_W:0]     err_sum;
    logic [COORD_W-1:0]        next_x;
    logic [COORD_W-1:0]        next_y;

    logic [COORD_W-1:0]        sel_x;
    logic [COORD_W-1:0]        sel_y;
    logic [COORD_W+ROW_W-1:0]  sel_prod;
    logic [INDEX_W-1:0]        sel_index;

    // Unpack the input transfer.
    assign in_sx = in_data[COORD_W-1:0];
    assign in_sy = in_data[2*COORD_W-1:COORD_W];
    assign in_ex = in_data[3*COORD_W-1:2*COORD_W];
    assign in_ey = in_data[4*COORD_W-1:3*COORD_W];

    // Spans are the true magnitudes of the differences.
    assign load_dx  = (in_ex >= in_sx) ? (in_ex - in_sx) : (in_sx - in_ex);
    assign load_dy  = (in_ey >= in_sy) ? (in_ey - in_sy) : (in_sy - in_ey);
    assign load_err = $signed({2'b00, load_dx}) - $signed({2'b00, load_dy});

    // One Bresenham step from the current walk cell.
    assign e2      = $signed({err_reg, 1'b0});
    assign dx_s    = $signed({3'b000, span_x_reg});
    assign neg_dy  = (ERR_W+1)'(0) - $signed({3'b000, span_y_reg});
    assign step_x  = e2 > neg_dy;
    assign step_y  = e2 < dx_s;
    assign err_sum = $signed({err_reg[ERR_W-1], err_reg})
                     + (step_x ? neg_dy : (ERR_W+1)'(0))
                     + (step_y ? dx_s : (ERR_W+1)'(0));
    assign next_x  = !step_x ? walk_x_reg
                   : (dir_x_neg_reg ? walk_x_reg - 1'b1 : walk_x_reg + 1'b1);
    assign next_y  = !step_y ? walk_y_reg
                   : (dir_y_neg_reg ? walk_y_reg - 1'b1 : walk_y_reg + 1'b1);

    assign status.same_point = (span_x_reg == '0) && (span_y_reg == '0);
    assign status.walk_last  = (next_x == goal_x_reg) && (next_y == goal_y_reg);

    // Linear index of the cell about to be loaded into the output register.
    assign sel_x     = cmd.emit_end ? goal_x_reg : walk_x_reg;
    assign sel_y     = cmd.emit_end ? goal_y_reg : walk_y_reg;
    assign sel_prod  = sel_y * row_width_reg;
    assign sel_index = sel_prod[INDEX_W-1:0] + {{(INDEX_W-COORD_W){1'b0}}, sel_x};

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            row_width_reg <= cfg_data;
        end
    end

    // Line set-up and walk registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            dir_x_neg_reg <= 1'b0;
            dir_y_neg_reg <= 1'b0;
            err_reg       <= '0;
        end
        else if (cmd.load)
        begin
            walk_x_reg    <= in_sx;
            walk_y_reg    <= in_sy;
            goal_x_reg    <= in_ex;
            goal_y_reg    <= in_ey;
            span_x_reg    <= load_dx;
            span_y_reg    <= load_dy;
            dir_x_neg_reg <= !(in_sx < in_ex);
            dir_y_neg_reg <= !(in_sy < in_ey);
            err_reg       <= load_err;
        end
        else if (cmd.emit_walk)
        begin
            walk_x_reg <= next_x;
            walk_y_reg <= next_y;
            err_reg    <= err_sum[ERR_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_x_reg     <= '0;
            cell_y_reg     <= '0;
            cell_index_reg <= '0;
            last_reg       <= 1'b0;
        end
        else if (cmd.emit_end || cmd.emit_walk)
        begin
            cell_x_reg     <= sel_x;
            cell_y_reg     <= sel_y;
            cell_index_reg <= sel_index;
            last_reg       <= cmd.emit_end ? status.same_point : status.walk_last;
        end
    end

    assign out_data = {cell_index_reg, cell_y_reg, cell_x_reg};
    assign out_last = last_reg;

endmodule

// ----- src/line_cell_rasterizer.sv -----
// Channel   Direction  Handshake              Payload
// s_        in         s_tvalid / s_tready    one line: start and end points
// m_        out        m_tvalid / m_tready    one cell per transfer, tlast on the final cell
// cfg_      in         cfg_valid / cfg_ready  row_width
//
// A line of N cells (N = max(|dx|, |dy|) + 1, at most 64) is taken in one
// input transfer; then the single Bresenham step unit gives one cell per cycle
// while the output does not stall.
// Reset is asynchronous and active low; row_width returns to 64.
// Output stalls hold the walk; the block takes a new line once the final cell
// has been loaded into the output register.
module line_cell_rasterizer
    import lcr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // start_x, start_y, end_x, end_y
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // cell_x, cell_y, cell_index
    output logic             m_tlast,   // last_cell
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [ROW_W-1:0] cfg_data   // row_width
);

    lcr_cmd_t    cmd;
    lcr_status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer.
    lcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Walk state, index and output register.
    lcr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef SYNTH
    // Only one datapath command is issued in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.emit_end, cmd.emit_walk}))
        else $error("more than one datapath command at once");

    // A new line is not taken in the cycle after one has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a line is being set up");

    // Loading the final walk cell frees the block for the next line.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_walk && status.walk_last) |=> s_tready)
        else $error("block not ready after the final cell of a line");

    // A loaded cell is always presented on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_end || cmd.emit_walk) |=> m_tvalid)
        else $error("loaded cell not presented");
`endif

endmodule
